FILE: rtl/wfc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// wfc_pkg
// Shared codes, token and write types of the word frequency counter.
// -----------------------------------------------------------------------------
package wfc_pkg;

	localparam logic [1:0] REQ_TEXT  = 2'd0;
	localparam logic [1:0] REQ_READ  = 2'd1;
	localparam logic [1:0] REQ_CLEAR = 2'd2;
	localparam logic [1:0] REQ_UNDEF = 2'd3;

	localparam logic [1:0] KIND_KNOWN = 2'd0;
	localparam logic [1:0] KIND_NEW   = 2'd1;
	localparam logic [1:0] KIND_DROP  = 2'd2;
	localparam logic [1:0] KIND_READ  = 2'd3;

	localparam int SLOT_MAX_W = 12;
	localparam int CNT_MAX_W  = 32;

	typedef struct packed {
		logic                  rd;
		logic [63:0]           head;
		logic [23:0]           tail;
		logic [3:0]            len;
		logic                  trunc;
		logic                  found;
		logic [SLOT_MAX_W-1:0] slot;
		logic [CNT_MAX_W-1:0]  cnt;
	} token_t;

	typedef struct packed {
		logic                  en;
		logic [SLOT_MAX_W-1:0] addr;
		logic [63:0]           head;
		logic [23:0]           tail;
		logic [3:0]            len;
	} wr_t;

	function automatic logic is_delim(input logic [7:0] b);
		unique case (b)
			8'h00, 8'h20, 8'h0A, 8'h22, 8'h2E, 8'h2C,
			8'h3B, 8'h3A, 8'h21, 8'h3F, 8'h29, 8'h28: is_delim = 1'b1;
			default: is_delim = 1'b0;
		endcase
	endfunction

endpackage
`default_nettype wire

FILE: rtl/wfc_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// wfc_cell
// One table slot: holds a word and its count, compares the passing token.
// -----------------------------------------------------------------------------
module wfc_cell import wfc_pkg::*; #(
	parameter int IDX = 0,
	parameter int CW  = 16,
	parameter int WCW = 10
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           vld_in,
	input  wire token_t         tok_in,
	input  wire logic [WCW-1:0] words,
	input  wire wr_t            wr,
	output logic                vld_out,
	output token_t              tok_out
);

	localparam logic [SLOT_MAX_W-1:0] ME = SLOT_MAX_W'(IDX);
	localparam logic [CW-1:0] CMAX = {CW{1'b1}};

	logic [63:0]   head_q;
	logic [23:0]   tail_q;
	logic [3:0]    len_q;
	logic [CW-1:0] cnt_q;
	logic          used;
	logic          hit;
	logic          sel;
	logic [CW-1:0] cnt_inc;
	token_t        tok_d;

	assign used    = WCW'(IDX) < words;
	assign hit     = vld_in && !tok_in.rd && !tok_in.found && used &&
	                 head_q == tok_in.head && tail_q == tok_in.tail &&
	                 len_q == tok_in.len;
	assign sel     = vld_in && tok_in.rd && used && tok_in.slot == ME;
	assign cnt_inc = (cnt_q < CMAX) ? cnt_q + CW'(1) : cnt_q;

	always_comb begin
		tok_d = tok_in;
		if (hit) begin
			tok_d.found = 1'b1;
			tok_d.slot  = ME;
			tok_d.cnt   = CNT_MAX_W'(cnt_inc);
		end
		if (sel) begin
			tok_d.head = head_q;
			tok_d.tail = tail_q;
			tok_d.len  = len_q;
			tok_d.cnt  = CNT_MAX_W'(cnt_q);
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en && wr.addr == ME) begin
			head_q <= wr.head;
			tail_q <= wr.tail;
			len_q  <= wr.len;
			cnt_q  <= CW'(1);
		end else if (hit) begin
			cnt_q <= cnt_inc;
		end
		tok_out <= tok_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out <= 1'b0;
		end else begin
			vld_out <= vld_in;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/word_frequency_counter.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// word_frequency_counter
// Counts distinct words of a text byte stream in a row of table cells.
// -----------------------------------------------------------------------------
// Input words carry a request in s_tuser: a text byte, a table read or a
// table clear. s_tlast on a text byte closes the open word after that byte.
// A text byte that does not close a word and a clear send no token.
// A closing word or a read sends a token down the row of TABLE_DEPTH cells,
// one cell a cycle; each cell registers the token, the end of the row holds
// it in an end register, and the result is then registered on the m_ side.
// No new word is taken while a token is in the row or in the end register.
// Results leave through an output register on the m_ side; s_tready does not
// depend on m_tready. If the receiver stalls, the token waits at the end of
// the row and s_tready stays low until the result can be registered.
// Reset empties the table count and the open word; the slots themselves are
// not cleared and need no clearing pass.
// -----------------------------------------------------------------------------
module word_frequency_counter import wfc_pkg::*; #(
	parameter int TABLE_DEPTH = 512,
	parameter int WORD_CHARS  = 11,
	parameter int COUNT_WIDTH = 16,
	localparam int IW  = $clog2(TABLE_DEPTH),
	localparam int WCW = $clog2(TABLE_DEPTH + 1),
	localparam int SDW = ((8 + IW + 7) / 8) * 8,
	localparam int MRW = IW + COUNT_WIDTH + 64 + 24 + 4 + 1 + WCW,
	localparam int MDW = ((MRW + 7) / 8) * 8
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           s_tvalid,
	output logic                s_tready,
	// text_byte, entry_index
	input  wire logic [SDW-1:0] s_tdata,
	// req_type
	input  wire logic [1:0]     s_tuser,
	input  wire logic           s_tlast,
	output logic                m_tvalid,
	input  wire logic           m_tready,
	// slot_index, occurrences, word_head, word_tail, word_length, truncated,
	// words_stored
	output logic [MDW-1:0]      m_tdata,
	// result_kind
	output logic [1:0]          m_tuser
);

	logic [87:0]    open_q;
	logic [3:0]     open_len_q;
	logic           open_trunc_q;
	logic [WCW-1:0] words_q;
	logic           busy_q;
	token_t         end_q;
	logic           end_vld_q;

	logic [IW+COUNT_WIDTH-1:0]       out_a_q;
	logic [63:0]                     out_head_q;
	logic [23:0]                     out_tail_q;
	logic [3:0]                      out_len_q;
	logic                            out_trunc_q;
	logic [WCW-1:0]                  out_words_q;
	logic [1:0]                      out_kind_q;

	logic           acc;
	logic [7:0]     tbyte;
	logic [IW-1:0]  eidx;
	logic           delim;
	logic [87:0]    app_word;
	logic [3:0]     app_len;
	logic           app_trunc;
	logic           launch;
	logic           fin;
	token_t         tok0;
	wr_t            wr;

	logic [TABLE_DEPTH:0] tv;
	token_t               tk [0:TABLE_DEPTH];

	assign s_tready = !busy_q;
	assign acc      = s_tvalid && s_tready;
	assign tbyte    = s_tdata[7:0];
	assign eidx     = s_tdata[8+IW-1:8];
	assign delim    = is_delim(tbyte);

	always_comb begin
		app_word  = open_q;
		app_len   = open_len_q;
		app_trunc = open_trunc_q;
		if (open_len_q < 4'(WORD_CHARS)) begin
			for (int k = 0; k < 11; k++) begin
				if (open_len_q == 4'(k)) app_word[8*k +: 8] = tbyte;
			end
			app_len = open_len_q + 4'd1;
		end else begin
			app_trunc = 1'b1;
		end
	end

	always_comb begin
		tok0  = '0;
		launch = 1'b0;
		if (acc && s_tuser == REQ_READ) begin
			launch    = 1'b1;
			tok0.rd   = 1'b1;
			tok0.slot = SLOT_MAX_W'(eidx);
		end else if (acc && s_tuser == REQ_TEXT) begin
			if (delim) begin
				launch     = open_len_q != 4'd0;
				tok0.head  = open_q[63:0];
				tok0.tail  = open_q[87:64];
				tok0.len   = open_len_q;
				tok0.trunc = open_trunc_q;
			end else if (s_tlast) begin
				launch     = 1'b1;
				tok0.head  = app_word[63:0];
				tok0.tail  = app_word[87:64];
				tok0.len   = app_len;
				tok0.trunc = app_trunc;
			end
		end
	end

	assign tv[0] = launch;
	assign tk[0] = tok0;

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		wfc_cell #(.IDX(i), .CW(COUNT_WIDTH), .WCW(WCW)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.vld_in  (tv[i]),
			.tok_in  (tk[i]),
			.words   (words_q),
			.wr      (wr),
			.vld_out (tv[i+1]),
			.tok_out (tk[i+1])
		);
	end

	assign fin = end_vld_q && (!m_tvalid || m_tready);

	always_comb begin
		wr      = '0;
		wr.addr = SLOT_MAX_W'(words_q);
		wr.head = end_q.head;
		wr.tail = end_q.tail;
		wr.len  = end_q.len;
		wr.en   = fin && !end_q.rd && !end_q.found &&
		          words_q < WCW'(TABLE_DEPTH);
	end

	always_ff @(posedge clk) begin
		if (tv[TABLE_DEPTH]) end_q <= tk[TABLE_DEPTH];
		if (fin) begin
			out_head_q  <= end_q.head;
			out_tail_q  <= end_q.tail;
			out_len_q   <= end_q.len;
			out_trunc_q <= end_q.rd ? 1'b0 : end_q.trunc;
			priority if (end_q.rd) begin
				out_kind_q  <= KIND_READ;
				out_a_q     <= {COUNT_WIDTH'(end_q.cnt), IW'(end_q.slot)};
				out_words_q <= words_q;
			end else if (end_q.found) begin
				out_kind_q  <= KIND_KNOWN;
				out_a_q     <= {COUNT_WIDTH'(end_q.cnt), IW'(end_q.slot)};
				out_words_q <= words_q;
			end else if (wr.en) begin
				out_kind_q  <= KIND_NEW;
				out_a_q     <= {COUNT_WIDTH'(1), IW'(words_q)};
				out_words_q <= words_q + WCW'(1);
			end else begin
				out_kind_q  <= KIND_DROP;
				out_a_q     <= '0;
				out_words_q <= words_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q       <= '0;
			open_len_q   <= '0;
			open_trunc_q <= 1'b0;
			words_q      <= '0;
			busy_q       <= 1'b0;
			end_vld_q    <= 1'b0;
			m_tvalid     <= 1'b0;
		end else begin
			if (acc && s_tuser == REQ_TEXT) begin
				if (delim || s_tlast) begin
					open_q       <= '0;
					open_len_q   <= '0;
					open_trunc_q <= 1'b0;
				end else begin
					open_q       <= app_word;
					open_len_q   <= app_len;
					open_trunc_q <= app_trunc;
				end
			end
			if (acc && s_tuser == REQ_CLEAR) words_q <= '0;
			else if (wr.en) words_q <= words_q + WCW'(1);
			if (launch) busy_q <= 1'b1;
			else if (fin) busy_q <= 1'b0;
			if (tv[TABLE_DEPTH]) end_vld_q <= 1'b1;
			else if (fin) end_vld_q <= 1'b0;
			if (fin) m_tvalid <= 1'b1;
			else if (m_tready) m_tvalid <= 1'b0;
		end
	end

	assign m_tuser = out_kind_q;
	assign m_tdata = MDW'({out_words_q, out_trunc_q, out_len_q, out_tail_q,
	                       out_head_q, out_a_q});

	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({tv, end_vld_q}))
		else $error("more than one token in the row");
	a_busy_token: assert property (@(posedge clk) disable iff (!arst_n)
		(tv[TABLE_DEPTH:1] != '0 || end_vld_q) |-> busy_q)
		else $error("token in flight while idle");
	a_words_bound: assert property (@(posedge clk) disable iff (!arst_n)
		words_q <= WCW'(TABLE_DEPTH))
		else $error("word count beyond table depth");
	a_fin_result: assert property (@(posedge clk) disable iff (!arst_n)
		fin |=> m_tvalid && !busy_q)
		else $error("finished token gave no result");

endmodule
`default_nettype wire
